// ===== rtl/aip_pkg.sv =====
// ============================================================================
// aip_pkg: shared types and constants of the ASCII integer parser
// Holds the register set, the scan phase and status codes, the character
// constants and the record that the scan stage hands to the result stage.
// ============================================================================
`default_nettype none

package aip_pkg;

    // Widths of the fixed fields.
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned BASE_W   = 5;
    localparam int unsigned WSEL_W   = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // Extra product bits needed for acc * base + digit with base up to 16.
    localparam int unsigned PROD_W = VALUE_W + BASE_W;

    // Character constants.
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;

    // Base limits and defaults.
    localparam logic [BASE_W-1:0] BASE_MIN    = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX    = 5'd16;
    localparam logic [BASE_W-1:0] BASE_SIGNED = 5'd10;
    localparam logic [BASE_W-1:0] BASE_RESET  = 5'd10;
    localparam logic [WSEL_W-1:0] WSEL_RESET  = 2'd3;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUMBER_BASE  = 2'd0,
        REG_SIGNED_MODE  = 2'd1,
        REG_WIDTH_SELECT = 2'd2
    } reg_index_t;

    // Result width codes.
    typedef enum logic [WSEL_W-1:0] {
        WSEL_8  = 2'd0,
        WSEL_16 = 2'd1,
        WSEL_32 = 2'd2,
        WSEL_64 = 2'd3
    } wsel_t;

    // Status codes, also used as the sticky error code.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_SYNTAX = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    // Scan phase of the text.
    typedef enum logic [1:0] {
        PH_SPACE = 2'd0,
        PH_TOKEN = 2'd1,
        PH_DONE  = 2'd2
    } phase_t;

    // Configuration register set.
    typedef struct packed {
        logic [BASE_W-1:0] number_base;
        logic              signed_mode;
        logic [WSEL_W-1:0] width_select;
    } cfg_t;

    // Parse outcome of one text, handed to the range check.
    typedef struct packed {
        logic [VALUE_W-1:0] magnitude;
        logic               negative;
        status_t            status;
    } fin_t;

endpackage : aip_pkg

`default_nettype wire

// ===== rtl/aip_if.sv =====
// ============================================================================
// aip_if: channel interfaces of the ASCII integer parser
// Character input channel, result output channel and configuration write
// channel, each with valid/ready and a source and a sink modport.
// ============================================================================
`default_nettype none

interface aip_in_if;
    logic                        valid;
    logic                        ready;
    logic [aip_pkg::CHAR_W-1:0]  char_code;
    logic                        last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface : aip_in_if

interface aip_out_if;
    logic                          valid;
    logic                          ready;
    logic [aip_pkg::VALUE_W-1:0]   value_bits;
    logic [aip_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output value_bits, output status, input ready);
    modport sink   (input valid, input value_bits, input status, output ready);
endinterface : aip_out_if

interface aip_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [aip_pkg::CFG_IDX_W-1:0]   index;
    logic [aip_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : aip_cfg_if

`default_nettype wire

// ===== rtl/aip_cfg.sv =====
// ============================================================================
// aip_cfg: configuration registers
// Takes one register write per beat; writes to unknown indexes are dropped.
// ============================================================================
`default_nettype none

module aip_cfg (
    input  wire logic     clk,
    input  wire logic     rst_n,
    aip_cfg_if.sink       cfg,
    output aip_pkg::cfg_t regs
);

    aip_pkg::cfg_t regs_reg;
    aip_pkg::cfg_t regs_next;

    // The register file never stalls a write.
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Decode the written index.
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (aip_pkg::reg_index_t'(cfg.index))
                aip_pkg::REG_NUMBER_BASE:
                    regs_next.number_base = cfg.data[aip_pkg::BASE_W-1:0];
                aip_pkg::REG_SIGNED_MODE:
                    regs_next.signed_mode = cfg.data[0];
                aip_pkg::REG_WIDTH_SELECT:
                    regs_next.width_select = cfg.data[aip_pkg::WSEL_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.number_base  <= aip_pkg::BASE_RESET;
            regs_reg.signed_mode  <= 1'b0;
            regs_reg.width_select <= aip_pkg::WSEL_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule : aip_cfg

`default_nettype wire

// ===== rtl/aip_scan.sv =====
// ============================================================================
// aip_scan: input register and character scanner
// Registers each character beat, then advances the parse state by one
// character per cycle, unless a last character waits for the outcome
// register: whitespace skip, sign, digit check and the multiply-accumulate.
// On the last character the outcome is registered for the range check
// and the parse state returns to its start.
`default_nettype none

module aip_scan (
    input  wire logic           clk,
    input  wire logic           rst_n,
    aip_in_if.sink              char_ch,
    input  wire aip_pkg::cfg_t  cfg,
    input  wire logic           fin_ready,
    output logic                fin_valid,
    output aip_pkg::fin_t       fin
);

    // Input register.
    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic [aip_pkg::CHAR_W-1:0]  in_char_reg;
    logic                        in_last_reg;

    // Parse state.
    logic [aip_pkg::VALUE_W-1:0] acc_reg;
    logic [aip_pkg::VALUE_W-1:0] acc_next;
    aip_pkg::phase_t             phase_reg;
    aip_pkg::phase_t             phase_next;
    logic                        neg_reg;
    logic                        neg_next;
    logic                        seen_reg;
    logic                        seen_next;
    aip_pkg::status_t            err_reg;
    aip_pkg::status_t            err_next;

    // Outcome register.
    logic                        fin_valid_reg;
    logic                        fin_valid_next;
    aip_pkg::fin_t               fin_reg;
    aip_pkg::fin_t               fin_upd;

    // Character decode and digit step.
    logic                        is_blank;
    logic                        is_digit;
    logic [aip_pkg::CHAR_W-1:0]  digit_diff;
    logic [3:0]                  digit_val;
    logic [aip_pkg::BASE_W-1:0]  base_eff;
    logic                        digit_ok;
    logic [aip_pkg::PROD_W-1:0]  prod;
    logic [aip_pkg::VALUE_W-1:0] td_acc;
    logic                        td_seen;
    aip_pkg::status_t            td_err;

    // Updated state before the end-of-text clear.
    logic [aip_pkg::VALUE_W-1:0] upd_acc;
    aip_pkg::phase_t             upd_phase;
    logic                        upd_neg;
    logic                        upd_seen;
    aip_pkg::status_t            upd_err;

    logic                        accept;
    logic                        fin_free;
    logic                        scan_fire;

    // Handshake: a plain character never waits; the last one needs the
    // outcome register free.
    assign accept    = char_ch.valid && char_ch.ready;
    assign fin_free  = !fin_valid_reg || fin_ready;
    assign scan_fire = in_valid_reg && (!in_last_reg || fin_free);
    assign char_ch.ready = !in_valid_reg || scan_fire;

    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

    // Classify the character.
    always_comb
    begin
        is_blank   = (in_char_reg == aip_pkg::CHAR_SPACE) ||
                     (in_char_reg inside {[aip_pkg::CHAR_TAB:aip_pkg::CHAR_CR]});
        is_digit   = 1'b1;
        digit_diff = '0;
        if (in_char_reg inside {[aip_pkg::CHAR_0:aip_pkg::CHAR_9]})
        begin
            digit_diff = in_char_reg - aip_pkg::CHAR_0;
        end
        else if (in_char_reg inside {[aip_pkg::CHAR_UA:aip_pkg::CHAR_UF]})
        begin
            digit_diff = in_char_reg - aip_pkg::CHAR_UA + 8'd10;
        end
        else if (in_char_reg inside {[aip_pkg::CHAR_LA:aip_pkg::CHAR_LF]})
        begin
            digit_diff = in_char_reg - aip_pkg::CHAR_LA + 8'd10;
        end
        else
        begin
            is_digit = 1'b0;
        end
        digit_val = digit_diff[3:0];
    end

    // Active base: ten in signed mode, otherwise the register clamped to 2..16.
    always_comb
    begin
        if (cfg.signed_mode)
        begin
            base_eff = aip_pkg::BASE_SIGNED;
        end
        else if (cfg.number_base < aip_pkg::BASE_MIN)
        begin
            base_eff = aip_pkg::BASE_MIN;
        end
        else if (cfg.number_base > aip_pkg::BASE_MAX)
        begin
            base_eff = aip_pkg::BASE_MAX;
        end
        else
        begin
            base_eff = cfg.number_base;
        end
    end

    // Digit step: acc * base + digit with the carry-out bits as overflow flag.
    always_comb
    begin
        digit_ok = is_digit && ({1'b0, digit_val} < base_eff);
        prod     = aip_pkg::PROD_W'(acc_reg) * aip_pkg::PROD_W'(base_eff) +
                   aip_pkg::PROD_W'(digit_val);
        td_acc   = acc_reg;
        td_seen  = seen_reg;
        td_err   = err_reg;
        if (!digit_ok)
        begin
            td_err = aip_pkg::ST_SYNTAX;
        end
        else
        begin
            td_seen = 1'b1;
            if (err_reg == aip_pkg::ST_OK)
            begin
                if (prod[aip_pkg::PROD_W-1:aip_pkg::VALUE_W] != '0)
                begin
                    td_err = aip_pkg::ST_RANGE;
                end
                else
                begin
                    td_acc = prod[aip_pkg::VALUE_W-1:0];
                end
            end
        end
    end

    // Phase logic: skip whitespace, open the token, close it on a separator.
    always_comb
    begin
        upd_acc   = acc_reg;
        upd_phase = phase_reg;
        upd_neg   = neg_reg;
        upd_seen  = seen_reg;
        upd_err   = err_reg;
        case (phase_reg)
            aip_pkg::PH_SPACE:
            begin
                if (!is_blank)
                begin
                    upd_phase = aip_pkg::PH_TOKEN;
                    if (cfg.signed_mode && (in_char_reg == aip_pkg::CHAR_MINUS))
                    begin
                        upd_neg = 1'b1;
                    end
                    else
                    begin
                        upd_acc  = td_acc;
                        upd_seen = td_seen;
                        upd_err  = td_err;
                    end
                end
            end
            aip_pkg::PH_TOKEN:
            begin
                if (is_blank || (in_char_reg == aip_pkg::CHAR_NUL))
                begin
                    upd_phase = aip_pkg::PH_DONE;
                end
                else
                begin
                    upd_acc  = td_acc;
                    upd_seen = td_seen;
                    upd_err  = td_err;
                end
            end
            default:
            begin
                upd_phase = phase_reg;
            end
        endcase
    end

    // Outcome of a finished text.
    always_comb
    begin
        fin_upd.magnitude = upd_acc;
        fin_upd.negative  = upd_neg;
        if ((upd_phase == aip_pkg::PH_SPACE) || !upd_seen)
        begin
            fin_upd.status = aip_pkg::ST_SYNTAX;
        end
        else
        begin
            fin_upd.status = upd_err;
        end
    end

    // Next-state selection.
    always_comb
    begin
        in_valid_next  = in_valid_reg;
        fin_valid_next = fin_valid_reg;
        acc_next       = acc_reg;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        seen_next      = seen_reg;
        err_next       = err_reg;
        if (scan_fire)
        begin
            in_valid_next = 1'b0;
        end
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        if (fin_ready)
        begin
            fin_valid_next = 1'b0;
        end
        if (scan_fire)
        begin
            if (in_last_reg)
            begin
                fin_valid_next = 1'b1;
                acc_next       = '0;
                phase_next     = aip_pkg::PH_SPACE;
                neg_next       = 1'b0;
                seen_next      = 1'b0;
                err_next       = aip_pkg::ST_OK;
            end
            else
            begin
                acc_next   = upd_acc;
                phase_next = upd_phase;
                neg_next   = upd_neg;
                seen_next  = upd_seen;
                err_next   = upd_err;
            end
        end
    end

    // Control and parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            acc_reg       <= '0;
            phase_reg     <= aip_pkg::PH_SPACE;
            neg_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            err_reg       <= aip_pkg::ST_OK;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            fin_valid_reg <= fin_valid_next;
            acc_reg       <= acc_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            seen_reg      <= seen_next;
            err_reg       <= err_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_char_reg <= char_ch.char_code;
            in_last_reg <= char_ch.last_char;
        end
        if (scan_fire && in_last_reg)
        begin
            fin_reg <= fin_upd;
        end
    end

endmodule : aip_scan

`default_nettype wire

// ===== rtl/aip_result.sv =====
// ============================================================================
// aip_result: range check and result register
// Checks the parsed magnitude against the selected width, applies the sign
// and holds the result beat until the receiver takes it.
// ============================================================================
`default_nettype none

module aip_result (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire aip_pkg::cfg_t  cfg,
    input  wire logic           fin_valid,
    input  wire aip_pkg::fin_t  fin,
    output logic                fin_ready,
    aip_out_if.source           result_ch
);

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [aip_pkg::VALUE_W-1:0]   out_value_reg;
    logic [aip_pkg::VALUE_W-1:0]   out_value_next;
    aip_pkg::status_t              out_status_reg;
    aip_pkg::status_t              out_status_next;

    logic [aip_pkg::VALUE_W-1:0]   mask;
    logic [aip_pkg::VALUE_W-1:0]   half;
    logic [aip_pkg::VALUE_W-1:0]   negated;
    logic                          load;

    // The result register takes a new beat when empty or being drained.
    assign fin_ready = !out_valid_reg || result_ch.ready;
    assign load      = fin_valid && fin_ready;

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.value_bits = out_value_reg;
    assign result_ch.status     = out_status_reg;

    // Width mask and the magnitude of the most negative value.
    always_comb
    begin
        case (aip_pkg::wsel_t'(cfg.width_select))
            aip_pkg::WSEL_8:
            begin
                mask = 64'h0000_0000_0000_00FF;
                half = 64'h0000_0000_0000_0080;
            end
            aip_pkg::WSEL_16:
            begin
                mask = 64'h0000_0000_0000_FFFF;
                half = 64'h0000_0000_0000_8000;
            end
            aip_pkg::WSEL_32:
            begin
                mask = 64'h0000_0000_FFFF_FFFF;
                half = 64'h0000_0000_8000_0000;
            end
            default:
            begin
                mask = 64'hFFFF_FFFF_FFFF_FFFF;
                half = 64'h8000_0000_0000_0000;
            end
        endcase
    end

    // Range check and sign application.
    always_comb
    begin
        negated         = '0 - fin.magnitude;
        out_value_next  = '0;
        out_status_next = fin.status;
        if (fin.status == aip_pkg::ST_OK)
        begin
            if (cfg.signed_mode)
            begin
                if (fin.negative)
                begin
                    if (fin.magnitude > half)
                    begin
                        out_status_next = aip_pkg::ST_RANGE;
                    end
                    else
                    begin
                        out_value_next = negated & mask;
                    end
                end
                else if (fin.magnitude >= half)
                begin
                    out_status_next = aip_pkg::ST_RANGE;
                end
                else
                begin
                    out_value_next = fin.magnitude;
                end
            end
            else if (fin.magnitude > mask)
            begin
                out_status_next = aip_pkg::ST_RANGE;
            end
            else
            begin
                out_value_next = fin.magnitude;
            end
        end
    end

    // Valid flag of the result register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
        end
    end

endmodule : aip_result

`default_nettype wire

// ===== rtl/ascii_integer_parser_top.sv =====
// ============================================================================
// ascii_integer_parser_top: streaming ASCII integer parser
// Parses one integer per text from a stream of characters, strtol style.
// ============================================================================
// Usage:
//   char_ch carries one character per beat; last_char marks the end of a text.
//   One beat is taken every cycle unless stalled, so texts stream back to back.
//   result_ch gives one beat per text, on its last character: value_bits
//   (two's complement in the selected width when signed, zero on error)
//   and status (ok, syntax error, overflow or out of range).
//   cfg writes number_base (index 0), signed_mode (1), width_select (2);
//   write only while no text is in flight.
// Path: from the input register, the digit step (64 x 5 bit multiply-add)
//   into the outcome register, then the range check into the result register.
// Throughput: one character per cycle, bounded by the digit step, while no
//   last character is held back by a full outcome register (see Stall).
// Reset: clears the parse state and the three valid flags; registers return to
//   base 10, unsigned, 64-bit width.
// Stall: a result held in the output register does not block characters;
//   only a second finished text waits, and char_ch.ready drops once both
//   the outcome and result registers are full and a last character waits.
// ============================================================================
`default_nettype none

module ascii_integer_parser_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    aip_in_if.sink     char_ch,
    aip_out_if.source  result_ch,
    aip_cfg_if.sink    cfg
);

    aip_pkg::cfg_t  regs;
    aip_pkg::fin_t  fin;
    logic           fin_valid;
    logic           fin_ready;

    // Configuration registers.
    aip_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Character scanner.
    aip_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_ch   (char_ch),
        .cfg       (regs),
        .fin_ready (fin_ready),
        .fin_valid (fin_valid),
        .fin       (fin)
    );

    // Range check and result register.
    aip_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (regs),
        .fin_valid (fin_valid),
        .fin       (fin),
        .fin_ready (fin_ready),
        .result_ch (result_ch)
    );

endmodule : ascii_integer_parser_top

`default_nettype wire

// ===== rtl/aip_checker.sv =====
// ============================================================================
// aip_checker: port-level checks of the ASCII integer parser
// Watches the result channel and is bound to the top level.
// ============================================================================
`default_nettype none

module aip_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [aip_pkg::VALUE_W-1:0]   out_value,
    input wire logic [aip_pkg::STATUS_W-1:0]  out_status
);

    // A result beat stays offered until it is taken.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped before it was taken");

    // A stalled result beat keeps its payload.
    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value) && $stable(out_status))
        else $error("result payload changed while stalled");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_status == aip_pkg::ST_OK) ||
                      (out_status == aip_pkg::ST_SYNTAX) ||
                      (out_status == aip_pkg::ST_RANGE))
        else $error("undefined status code on result");

    // A failed parse gives a zero value.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != aip_pkg::ST_OK) |-> (out_value == '0))
        else $error("nonzero value with error status");

endmodule : aip_checker

bind ascii_integer_parser_top aip_checker u_aip_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .out_value  (result_ch.value_bits),
    .out_status (result_ch.status)
);

`default_nettype wire
